// ----- sv/bucketed_search_result_cache_defines.svh -----
`ifndef BUCKETED_SEARCH_RESULT_CACHE_DEFINES_SVH
`define BUCKETED_SEARCH_RESULT_CACHE_DEFINES_SVH

// Plain property check, sampled on clock and disabled while in reset.
`define BSRC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When trig is seen, held must be true in the cycle after.
`define BSRC_ASSERT_NEXT(label, trig, held, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (held)) \
      else $error(msg);

`endif

// ----- sv/bsrc_pkg.sv -----
`default_nettype none
package bsrc_pkg;

   localparam int DEF_BUCKETS = 4096;
   localparam int DEF_WAYS    = 4;

   localparam int KEY_W   = 64;
   localparam int DATA_W  = 64;
   localparam int DEPTH_W = 8;
   localparam int SCORE_W = 16;
   localparam int MOVE_W  = 16;
   localparam int PLY_W   = 8;
   localparam int KIND_W  = 2;
   localparam int BOUND_W = 2;
   localparam int CFG_W   = 4;

   localparam int SCORE_EXT_W    = SCORE_W + 1;
   localparam int MAX_INDEX_BITS = (1 << CFG_W) - 1;

   localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(12);

   localparam int SCORE_SHIFT = 0;
   localparam int MOVE_SHIFT  = 16;
   localparam int FLAG_SHIFT  = 32;
   localparam int DEPTH_SHIFT = 48;

   localparam int MATE_SCORE  = 29000;
   localparam int MATE_WINDOW = 250;

   localparam logic signed [SCORE_EXT_W-1:0] MATE_TOP   = SCORE_EXT_W'(MATE_SCORE);
   localparam logic signed [SCORE_EXT_W-1:0] MATE_LO    = SCORE_EXT_W'(MATE_SCORE - MATE_WINDOW);
   localparam logic signed [SCORE_EXT_W-1:0] MATE_HI    = SCORE_EXT_W'(MATE_SCORE + MATE_WINDOW);
   localparam logic signed [SCORE_EXT_W-1:0] MATE_CLAMP =
      SCORE_EXT_W'(MATE_SCORE - MATE_WINDOW - 1);

   localparam logic [KIND_W-1:0] KIND_PROBE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROBE_ANY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STORE     = 2'd2;

   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
   localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
   localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]  check;
      logic [DATA_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [KEY_W-1:0]          key;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] alpha;
      logic signed [SCORE_W-1:0] beta;
      logic signed [SCORE_W-1:0] score;
      logic [BOUND_W-1:0]        bound_type;
      logic [MOVE_W-1:0]         best_move;
      logic [PLY_W-1:0]          ply;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic                      cutoff;
      logic signed [SCORE_W-1:0] score_out;
      logic [MOVE_W-1:0]         move_out;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/bucketed_search_result_cache.sv -----
// Bucketed search-result cache: a table of BUCKETS buckets of WAYS ways, one
// bucket line per memory row.
// req_*: one transaction per probe or store; accepted when req_valid is high and
//    req_stall low. Stores give no result, probes give one rsp_* transaction.
// rsp_*: result transaction, accepted when rsp_valid is high and rsp_stall low.
// csr_*: write of index_bits, taken when csr_valid and csr_ready are high;
//    csr_ready is always high. Write it only while no transaction is in flight.
// Flow: with BUCKETS a power of two the bucket index is combinational and the
//    bucket row is read as the transaction is accepted; the block then does the
//    compare, update and write-back and takes no new transaction until it is done.
//    Otherwise the bucket index is first reduced modulo BUCKETS by restoring
//    subtraction steps, and then the row is read.
// Reset: the table memory is cleared one row a cycle, all BUCKETS rows, with
//    req_stall high; index_bits returns to 12.
// When rsp_stall holds a result, the next probe completes its row read and then
//    waits in its compare state until the output register frees; a store still
//    completes.
`default_nettype none
module bucketed_search_result_cache
   import bsrc_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int WAYS    = DEF_WAYS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic [KEY_W-1:0]          req_key,
   input  wire logic [DEPTH_W-1:0]        req_depth,
   input  wire logic signed [SCORE_W-1:0] req_alpha,
   input  wire logic signed [SCORE_W-1:0] req_beta,
   input  wire logic signed [SCORE_W-1:0] req_score,
   input  wire logic [BOUND_W-1:0]        req_bound_type,
   input  wire logic [MOVE_W-1:0]         req_best_move,
   input  wire logic [PLY_W-1:0]          req_ply,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_hit,
   output logic                           rsp_cutoff,
   output logic signed [SCORE_W-1:0]      rsp_score_out,
   output logic [MOVE_W-1:0]              rsp_move_out,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CFG_W-1:0]          csr_index_bits
);

   localparam int ROW_W = $clog2(BUCKETS);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_LOOKUP
   } state_type;

   state_type            state_ff;
   logic [ROW_W-1:0]     clr_ff;
   logic [ROW_W-1:0]     row_ff;
   req_type              req_ff;
   req_type              req_bus;
   logic [CFG_W-1:0]     index_bits_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 req_accept;
   logic                 idx_done;
   logic [ROW_W-1:0]     idx_row;
   entry_type [WAYS-1:0] rd_row;
   entry_type [WAYS-1:0] new_row;
   logic                 mem_wr_en;
   logic [ROW_W-1:0]     mem_wr_addr;
   entry_type [WAYS-1:0] mem_wr_data;
   logic                 way_wr_en;
   logic [WAY_W-1:0]     way_wr_way;
   entry_type            way_wr_entry;
   logic                 way_has_rsp;
   rsp_type              way_rsp;
   logic                 out_free;
   logic                 finish;

   assign req_bus.kind       = req_kind;
   assign req_bus.key        = req_key;
   assign req_bus.depth      = req_depth;
   assign req_bus.alpha      = req_alpha;
   assign req_bus.beta       = req_beta;
   assign req_bus.score      = req_score;
   assign req_bus.bound_type = req_bound_type;
   assign req_bus.best_move  = req_best_move;
   assign req_bus.ply        = req_ply;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == ST_LOOKUP) && (!way_has_rsp || out_free);

   bsrc_index #(
      .BUCKETS(BUCKETS)
   ) u_index (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .key_low    (req_key[MAX_INDEX_BITS-1:0]),
      .index_bits (index_bits_ff),
      .done       (idx_done),
      .row        (idx_row)
   );

   bsrc_mem #(
      .BUCKETS(BUCKETS),
      .WAYS   (WAYS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (idx_done),
      .rd_addr (idx_row),
      .rd_data (rd_row),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   bsrc_way #(
      .WAYS(WAYS)
   ) u_way (
      .row      (rd_row),
      .req      (req_ff),
      .wr_en    (way_wr_en),
      .wr_way   (way_wr_way),
      .wr_entry (way_wr_entry),
      .has_rsp  (way_has_rsp),
      .rsp      (way_rsp)
   );

   always_comb begin
      new_row             = rd_row;
      new_row[way_wr_way] = way_wr_entry;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = finish && way_wr_en;
         mem_wr_addr = row_ff;
         mem_wr_data = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         index_bits_ff <= csr_index_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ROW_W'(1);
               if (clr_ff == ROW_W'(BUCKETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  req_ff   <= req_bus;
                  state_ff <= idx_done ? ST_LOOKUP : ST_INDEX;
               end
            end
            ST_INDEX: begin
               if (idx_done) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (finish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (idx_done) begin
            row_ff <= idx_row;
         end

         if (finish && way_has_rsp) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= way_rsp;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_cutoff    = rsp_ff.cutoff;
   assign rsp_score_out = rsp_ff.score_out;
   assign rsp_move_out  = rsp_ff.move_out;

endmodule
`default_nettype wire

// ----- sv/bsrc_mem.sv -----
`default_nettype none
module bsrc_mem
   import bsrc_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int WAYS    = DEF_WAYS,
   localparam int ROW_W  = $clog2(BUCKETS)
) (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire logic [ROW_W-1:0]       rd_addr,
   output entry_type [WAYS-1:0]        rd_data,
   input  wire logic                   wr_en,
   input  wire logic [ROW_W-1:0]       wr_addr,
   input  entry_type [WAYS-1:0]        wr_data
);

   entry_type [WAYS-1:0] mem_ff [BUCKETS];
   entry_type [WAYS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/bsrc_index.sv -----
`default_nettype none
module bsrc_index
   import bsrc_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   localparam int ROW_W  = $clog2(BUCKETS)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [MAX_INDEX_BITS-1:0] key_low,
   input  wire logic [CFG_W-1:0]          index_bits,
   output logic                           done,
   output logic [ROW_W-1:0]               row
);

   localparam int  IDX_W        = (ROW_W > MAX_INDEX_BITS) ? ROW_W : MAX_INDEX_BITS;
   localparam bit  BUCKETS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   logic [CFG_W-1:0]          bits_eff;
   logic [MAX_INDEX_BITS:0]   mask_w;
   logic [MAX_INDEX_BITS-1:0] masked;
   logic [IDX_W-1:0]          masked_ext;

   always_comb begin
      bits_eff   = (index_bits == '0) ? CFG_W'(1) : index_bits;
      mask_w     = ((MAX_INDEX_BITS + 1)'(1) << bits_eff) - (MAX_INDEX_BITS + 1)'(1);
      masked     = key_low & mask_w[MAX_INDEX_BITS-1:0];
      masked_ext = IDX_W'(masked);
   end

   generate
      if (BUCKETS_POW2) begin : g_pow2
         assign done = start;
         assign row  = masked_ext[ROW_W-1:0];
      end else begin : g_mod
         localparam int STEPS  = IDX_W - ROW_W + 1;
         localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

         logic             busy_ff;
         logic [IDX_W-1:0] rem_ff;
         logic [IDX_W-1:0] rem_in;
         logic [IDX_W-1:0] sub_val;
         logic [STEP_W-1:0] step_ff;

         // restoring reduction: one shifted multiple of the bucket count per cycle
         always_comb begin
            sub_val = IDX_W'(BUCKETS) << step_ff;
            rem_in  = (rem_ff >= sub_val) ? (rem_ff - sub_val) : rem_ff;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
            end else if (start) begin
               busy_ff <= 1'b1;
               rem_ff  <= masked_ext;
               step_ff <= STEP_W'(STEPS - 1);
            end else if (busy_ff) begin
               rem_ff  <= rem_in;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  busy_ff <= 1'b0;
               end
            end
         end

         assign done = busy_ff && (step_ff == '0);
         assign row  = rem_in[ROW_W-1:0];
      end
   endgenerate

endmodule
`default_nettype wire

// ----- sv/bsrc_way.sv -----
`default_nettype none
module bsrc_way
   import bsrc_pkg::*;
#(
   parameter int WAYS   = DEF_WAYS,
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  entry_type [WAYS-1:0] row,
   input  req_type              req,
   output logic                 wr_en,
   output logic [WAY_W-1:0]     wr_way,
   output entry_type            wr_entry,
   output logic                 has_rsp,
   output rsp_type              rsp
);

   logic [WAYS-1:0]    way_empty;
   logic [WAYS-1:0]    way_match;
   logic               match_found;
   logic               empty_found;
   logic               min_found;
   logic [WAY_W-1:0]   match_way;
   logic [WAY_W-1:0]   empty_way;
   logic [WAY_W-1:0]   min_way;
   logic [DEPTH_W-1:0] min_depth;
   logic [DEPTH_W-1:0] cur_depth;

   logic [DATA_W-1:0]              hit_data;
   logic [DEPTH_W-1:0]             hit_depth;
   logic [BOUND_W-1:0]             hit_flag;
   logic signed [SCORE_EXT_W-1:0]  stored;
   logic signed [SCORE_EXT_W-1:0]  adjusted;
   logic signed [SCORE_EXT_W-1:0]  ply_ext;
   logic signed [SCORE_EXT_W-1:0]  alpha_ext;
   logic signed [SCORE_EXT_W-1:0]  beta_ext;
   logic signed [SCORE_EXT_W-1:0]  in_score;
   logic signed [SCORE_EXT_W-1:0]  canon;
   logic                           cut;
   logic [DATA_W-1:0]              packed_data;

   always_comb begin
      match_found = 1'b0;
      empty_found = 1'b0;
      min_found   = 1'b0;
      match_way   = '0;
      empty_way   = '0;
      min_way     = '0;
      min_depth   = '0;
      cur_depth   = '0;
      for (int w = 0; w < WAYS; w++) begin
         way_empty[w] = (row[w].check == '0) && (row[w].data == '0);
         way_match[w] = !way_empty[w] && ((row[w].check ^ row[w].data) == req.key);
         cur_depth    = row[w].data[DEPTH_SHIFT +: DEPTH_W];
         if (way_match[w] && !match_found) begin
            match_found = 1'b1;
            match_way   = WAY_W'(w);
         end
         if (way_empty[w] && !empty_found) begin
            empty_found = 1'b1;
            empty_way   = WAY_W'(w);
         end
         if (!way_empty[w] && (!min_found || (cur_depth < min_depth))) begin
            min_found = 1'b1;
            min_way   = WAY_W'(w);
            min_depth = cur_depth;
         end
      end
   end

   always_comb begin
      hit_data  = row[match_way].data;
      hit_depth = hit_data[DEPTH_SHIFT +: DEPTH_W];
      hit_flag  = hit_data[FLAG_SHIFT +: BOUND_W];
      stored    = $signed({hit_data[SCORE_SHIFT + SCORE_W - 1],
                           hit_data[SCORE_SHIFT +: SCORE_W]});
      ply_ext   = $signed(SCORE_EXT_W'(req.ply));
      alpha_ext = $signed({req.alpha[SCORE_W-1], req.alpha});
      beta_ext  = $signed({req.beta[SCORE_W-1], req.beta});

      // undo the ply shift on mate scores
      if ((stored >= MATE_LO) && (stored <= MATE_HI)) begin
         adjusted = stored - ply_ext;
      end else if ((stored <= -MATE_LO) && (stored >= -MATE_HI)) begin
         adjusted = stored + ply_ext;
      end else begin
         adjusted = stored;
      end

      cut = (hit_flag == BOUND_EXACT) ||
            ((hit_flag == BOUND_UPPER) && (adjusted <= alpha_ext)) ||
            ((hit_flag == BOUND_LOWER) && (adjusted >= beta_ext));

      has_rsp = (req.kind == KIND_PROBE) || (req.kind == KIND_PROBE_ANY);
      rsp     = '0;
      if (match_found) begin
         rsp.hit      = 1'b1;
         rsp.move_out = hit_data[MOVE_SHIFT +: MOVE_W];
         if (req.kind == KIND_PROBE_ANY) begin
            rsp.cutoff    = 1'b1;
            rsp.score_out = stored[SCORE_W-1:0];
         end else if ((hit_depth >= req.depth) && cut) begin
            rsp.cutoff    = 1'b1;
            rsp.score_out = adjusted[SCORE_W-1:0];
         end
      end
   end

   always_comb begin
      in_score = $signed({req.score[SCORE_W-1], req.score});

      // clamp overshooting mate scores, shift real ones by ply
      if (in_score > MATE_TOP) begin
         canon = MATE_CLAMP;
      end else if (in_score >= MATE_LO) begin
         canon = in_score + ply_ext;
      end else if (in_score < -MATE_TOP) begin
         canon = -MATE_CLAMP;
      end else if (in_score <= -MATE_LO) begin
         canon = in_score - ply_ext;
      end else begin
         canon = in_score;
      end

      packed_data                            = '0;
      packed_data[SCORE_SHIFT +: SCORE_W]    = canon[SCORE_W-1:0];
      packed_data[MOVE_SHIFT +: MOVE_W]      = req.best_move;
      packed_data[FLAG_SHIFT +: BOUND_W]     = req.bound_type;
      packed_data[DEPTH_SHIFT +: DEPTH_W]    = req.depth;

      wr_entry.data  = packed_data;
      wr_entry.check = req.key ^ packed_data;

      if (match_found) begin
         wr_way = match_way;
         wr_en  = (req.kind == KIND_STORE) && !(hit_depth > req.depth);
      end else begin
         wr_way = empty_found ? empty_way : min_way;
         wr_en  = (req.kind == KIND_STORE);
      end
   end

endmodule
`default_nettype wire

// ----- sv/bsrc_checker.sv -----
`default_nettype none
`include "bucketed_search_result_cache_defines.svh"
module bsrc_checker
   import bsrc_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic                      rsp_hit,
   input wire logic                      rsp_cutoff,
   input wire logic signed [SCORE_W-1:0] rsp_score_out,
   input wire logic [MOVE_W-1:0]         rsp_move_out
);

   `BSRC_ASSERT_NEXT(a_accept_then_busy, req_valid && !req_stall, req_stall, "accepted transaction did not occupy the block")
   `BSRC_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> $past(req_stall), "result appeared with no transaction in flight")
   `BSRC_ASSERT(a_clear_after_reset, $fell(reset) |-> req_stall, "request taken before the table was cleared")
   `BSRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_cutoff) && $stable(rsp_score_out) && $stable(rsp_move_out), "stalled result changed")

endmodule

bind bucketed_search_result_cache bsrc_checker u_bsrc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_hit       (rsp_hit),
   .rsp_cutoff    (rsp_cutoff),
   .rsp_score_out (rsp_score_out),
   .rsp_move_out  (rsp_move_out)
);
`default_nettype wire

// ----- tb/cache_check_pkg.sv -----
`timescale 1ns / 1ps
package cache_check_pkg;
   import bsrc_pkg::*;

   localparam int TABLE_WORDS = DEF_BUCKETS * DEF_WAYS;

   class bucket_table_model;
      logic [KEY_W-1:0]  check_mem [TABLE_WORDS];
      logic [DATA_W-1:0] data_mem  [TABLE_WORDS];
      logic [CFG_W-1:0]  index_bits;
      rsp_type           pending_lookups [$];
      int                mismatches;
      int                stores_seen;
      int                lookups_checked;
      int                hits_seen;
      int                cutoffs_seen;

      function new();
         foreach (check_mem[i]) begin
            check_mem[i] = '0;
            data_mem[i]  = '0;
         end
         index_bits      = INDEX_BITS_RESET;
         mismatches      = 0;
         stores_seen     = 0;
         lookups_checked = 0;
         hits_seen       = 0;
         cutoffs_seen    = 0;
      endfunction

      function void set_index_bits(logic [CFG_W-1:0] value);
         index_bits = value;
      endfunction

      function int unsigned bucket_base(logic [KEY_W-1:0] key);
         int unsigned      bits;
         logic [KEY_W-1:0] idx;
         bits = (index_bits == 0) ? 1 : index_bits;
         idx  = key & ((64'd1 << bits) - 64'd1);
         idx  = idx % DEF_BUCKETS;
         return idx * DEF_WAYS;
      endfunction

      function bit way_empty(int unsigned slot);
         return check_mem[slot] == '0 && data_mem[slot] == '0;
      endfunction

      function int depth_of(logic [DATA_W-1:0] word);
         return int'(word[DEPTH_SHIFT +: DEPTH_W]);
      endfunction

      function void store_entry(req_type r);
         int unsigned       base;
         int unsigned       pick;
         int unsigned       slot;
         int                pick_depth;
         int                sc;
         int                s;
         int                ply;
         bit                matched;
         logic [DATA_W-1:0] word;
         base       = bucket_base(r.key);
         pick       = base;
         pick_depth = 1000;
         matched    = 1'b0;
         for (int w = 0; w < DEF_WAYS && !matched; w++) begin
            slot = base + w;
            if (way_empty(slot)) begin
               if (pick_depth > -1) begin
                  pick       = slot;
                  pick_depth = -1;
               end
            end else if ((check_mem[slot] ^ data_mem[slot]) == r.key) begin
               if (depth_of(data_mem[slot]) > int'(r.depth)) return;
               pick    = slot;
               matched = 1'b1;
            end else if (depth_of(data_mem[slot]) < pick_depth) begin
               pick       = slot;
               pick_depth = depth_of(data_mem[slot]);
            end
         end
         sc  = $signed(r.score);
         ply = r.ply;
         s   = sc;
         if (sc > MATE_SCORE) s = MATE_SCORE - MATE_WINDOW - 1;
         else if (sc >= MATE_SCORE - MATE_WINDOW) s = sc + ply;
         else if (sc < -MATE_SCORE) s = -(MATE_SCORE - MATE_WINDOW - 1);
         else if (sc <= -(MATE_SCORE - MATE_WINDOW)) s = sc - ply;
         word = {8'd0, r.depth, 14'd0, r.bound_type, r.best_move, s[15:0]};
         data_mem[pick]  = word;
         check_mem[pick] = r.key ^ word;
      endfunction

      function rsp_type lookup_result(req_type r);
         rsp_type           res;
         int unsigned       base;
         int unsigned       slot;
         logic [DATA_W-1:0] word;
         bit                found;
         bit                cut;
         int                stored;
         int                ply;
         int                alpha;
         int                beta;
         res   = '0;
         found = 1'b0;
         word  = '0;
         base  = bucket_base(r.key);
         for (int w = 0; w < DEF_WAYS && !found; w++) begin
            slot = base + w;
            if (!way_empty(slot) && (check_mem[slot] ^ data_mem[slot]) == r.key) begin
               word  = data_mem[slot];
               found = 1'b1;
            end
         end
         if (!found) return res;
         stored       = $signed(word[15:0]);
         res.hit      = 1'b1;
         res.move_out = word[MOVE_SHIFT +: MOVE_W];
         if (r.kind == KIND_PROBE_ANY) begin
            res.cutoff    = 1'b1;
            res.score_out = word[15:0];
            return res;
         end
         if (depth_of(word) >= int'(r.depth)) begin
            ply   = r.ply;
            alpha = $signed(r.alpha);
            beta  = $signed(r.beta);
            if (stored >= MATE_SCORE - MATE_WINDOW && stored <= MATE_SCORE + MATE_WINDOW)
               stored -= ply;
            else if (stored <= -(MATE_SCORE - MATE_WINDOW) &&
                     stored >= -(MATE_SCORE + MATE_WINDOW))
               stored += ply;
            cut = (word[FLAG_SHIFT +: BOUND_W] == BOUND_EXACT) ||
                  (word[FLAG_SHIFT +: BOUND_W] == BOUND_UPPER && stored <= alpha) ||
                  (word[FLAG_SHIFT +: BOUND_W] == BOUND_LOWER && stored >= beta);
            if (cut) begin
               res.cutoff    = 1'b1;
               res.score_out = stored[15:0];
            end
         end
         return res;
      endfunction

      function void note_request(req_type r);
         case (r.kind)
            KIND_STORE: begin
               store_entry(r);
               stores_seen++;
            end
            KIND_PROBE, KIND_PROBE_ANY: begin
               pending_lookups.push_back(lookup_result(r));
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_lookups.size() == 0) begin
            report_mismatch("result transaction with no lookup outstanding");
            return;
         end
         want = pending_lookups.pop_front();
         lookups_checked++;
         if (want.hit) hits_seen++;
         if (want.cutoff) cutoffs_seen++;
         if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
         if (got.cutoff !== want.cutoff)
            report_mismatch($sformatf("cutoff %b, expected %b", got.cutoff, want.cutoff));
         if (got.score_out !== want.score_out)
            report_mismatch($sformatf("score_out %0d, expected %0d",
                                      got.score_out, want.score_out));
         if (got.move_out !== want.move_out)
            report_mismatch($sformatf("move_out %h, expected %h",
                                      got.move_out, want.move_out));
      endtask
   endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import bsrc_pkg::*;
   import cache_check_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int POOL_SIZE     = 16;

   localparam logic [KIND_W-1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [BOUND_W-1:0] BOUND_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [KIND_W-1:0]         req_kind       = '0;
   logic [KEY_W-1:0]          req_key        = '0;
   logic [DEPTH_W-1:0]        req_depth      = '0;
   logic signed [SCORE_W-1:0] req_alpha      = '0;
   logic signed [SCORE_W-1:0] req_beta       = '0;
   logic signed [SCORE_W-1:0] req_score      = '0;
   logic [BOUND_W-1:0]        req_bound_type = '0;
   logic [MOVE_W-1:0]         req_best_move  = '0;
   logic [PLY_W-1:0]          req_ply        = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic                      rsp_hit;
   logic                      rsp_cutoff;
   logic signed [SCORE_W-1:0] rsp_score_out;
   logic [MOVE_W-1:0]         rsp_move_out;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CFG_W-1:0]          csr_index_bits = '0;

   bucketed_search_result_cache u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_depth      (req_depth),
      .req_alpha      (req_alpha),
      .req_beta       (req_beta),
      .req_score      (req_score),
      .req_bound_type (req_bound_type),
      .req_best_move  (req_best_move),
      .req_ply        (req_ply),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_cutoff     (rsp_cutoff),
      .rsp_score_out  (rsp_score_out),
      .rsp_move_out   (rsp_move_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index_bits (csr_index_bits)
   );

   bucket_table_model model;
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];
   bit                sender_idles = 1'b1;
   bit                rsp_idles    = 1'b1;
   bit                hold_request = 1'b0;
   int                requests_sent = 0;
   int                settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic req_type mk_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                          int depth, int alpha, int beta, int score,
                                          logic [BOUND_W-1:0] bound, int move, int ply);
      req_type r;
      r.kind       = kind;
      r.key        = key;
      r.depth      = DEPTH_W'(depth);
      r.alpha      = SCORE_W'(alpha);
      r.beta       = SCORE_W'(beta);
      r.score      = SCORE_W'(score);
      r.bound_type = bound;
      r.best_move  = MOVE_W'(move);
      r.ply        = PLY_W'(ply);
      return r;
   endfunction

   function automatic void build_key_pool();
      logic [11:0] low_bits [3];
      foreach (low_bits[i]) low_bits[i] = 12'($urandom);
      foreach (key_pool[i]) begin
         key_pool[i] = {$urandom, $urandom};
         if ($urandom_range(99) < 60) key_pool[i][11:0] = low_bits[$urandom_range(2)];
      end
      if ($urandom_range(3) == 0) key_pool[0] = '0;
   endfunction

   function automatic req_type make_random_request();
      req_type r;
      int      pick;
      int      mag;
      pick = $urandom_range(99);
      if (pick < 45) r.kind = KIND_STORE;
      else if (pick < 70) r.kind = KIND_PROBE;
      else if (pick < 94) r.kind = KIND_PROBE_ANY;
      else r.kind = KIND_UNUSED;
      r.key   = ($urandom_range(99) < 90) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                          : {$urandom, $urandom};
      r.depth = ($urandom_range(99) < 80) ? DEPTH_W'($urandom_range(12))
                                          : DEPTH_W'($urandom_range(255));
      r.alpha = SCORE_W'($urandom);
      r.beta  = SCORE_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.score = SCORE_W'($urandom);
      end else if (pick < 80) begin
         mag     = $urandom_range(29260, 28740);
         r.score = SCORE_W'($urandom_range(1) ? mag : -mag);
      end else if (pick < 90) begin
         case ($urandom_range(3))
            0: r.score = 16'sh7FFF;
            1: r.score = 16'sh8000;
            2: r.score = SCORE_W'(MATE_SCORE - MATE_WINDOW);
            default: r.score = SCORE_W'(-(MATE_SCORE - MATE_WINDOW));
         endcase
      end else begin
         r.score = SCORE_W'($urandom_range(200) - 100);
      end
      r.bound_type = ($urandom_range(99) < 90) ? BOUND_W'($urandom_range(2)) : BOUND_UNUSED;
      r.best_move  = MOVE_W'($urandom);
      r.ply        = ($urandom_range(99) < 85) ? PLY_W'($urandom_range(40))
                                               : PLY_W'($urandom_range(255));
      return r;
   endfunction

   task automatic send_request(input req_type r);
      req_valid      <= 1'b1;
      req_kind       <= r.kind;
      req_key        <= r.key;
      req_depth      <= r.depth;
      req_alpha      <= r.alpha;
      req_beta       <= r.beta;
      req_score      <= r.score;
      req_bound_type <= r.bound_type;
      req_best_move  <= r.best_move;
      req_ply        <= r.ply;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.note_request(r);
      requests_sent++;
   endtask

   task automatic pace_sender(input bit last);
      if (last) begin
         req_valid <= 1'b0;
      end else if (sender_idles && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_for_lookups();
      while (model.pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_index_bits(input logic [CFG_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_index_bits <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model.set_index_bits(value);
      settings_used++;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] bits, input int count, input bit pause_mid);
      wait_for_lookups();
      write_index_bits(bits);
      build_key_pool();
      for (int i = 0; i < count; i++) begin
         send_request(make_random_request());
         pace_sender(i == count - 1 || (pause_mid && i == count / 2));
         if (pause_mid && i == count / 2) wait_for_lookups();
      end
   endtask

   initial begin
      rsp_type got;
      int      hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.hit       = rsp_hit;
            got.cutoff    = rsp_cutoff;
            got.score_out = rsp_score_out;
            got.move_out  = rsp_move_out;
            model.check_result(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= rsp_idles && ($urandom_range(99) < 34);
         end
      end
   end

   initial begin
      req_type          directed [$];
      logic [KEY_W-1:0] k1;
      logic [KEY_W-1:0] k2;
      logic [KEY_W-1:0] k3;
      logic [KEY_W-1:0] k4;
      logic [KEY_W-1:0] k5;
      model = new();
      k1 = '1;
      k2 = 64'h0123_4567_89AB_CFFF;
      k3 = 64'hFEDC_BA98_7654_3FFF;
      k4 = 64'h8000_0000_0000_0FFF;
      k5 = 64'h5555_AAAA_5555_AFFF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // empty table, then an all-zero entry under key zero
      directed.push_back(mk_request(KIND_PROBE, '0, 0, -32768, 32767, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_PROBE_ANY, '0, 0, 0, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_STORE, '0, 0, 0, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_PROBE, '0, 0, -32768, 32767, 0, BOUND_EXACT, 0, 0));
      // one bucket filled past its ways
      directed.push_back(mk_request(KIND_STORE, k1, 255, 0, 0, 32767, BOUND_EXACT, 'hFFFF, 255));
      directed.push_back(mk_request(KIND_PROBE, k1, 255, -32768, 32767, 0, BOUND_EXACT, 0, 255));
      directed.push_back(mk_request(KIND_PROBE_ANY, k1, 0, 0, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_STORE, k1, 10, 0, 0, 5, BOUND_LOWER, 'h1234, 0));
      directed.push_back(mk_request(KIND_PROBE_ANY, k1, 0, 0, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_STORE, k2, 3, 0, 0, 28750, BOUND_UPPER, 'h0F0F, 7));
      directed.push_back(mk_request(KIND_PROBE, k2, 3, 32767, 0, 0, BOUND_EXACT, 0, 7));
      directed.push_back(mk_request(KIND_PROBE, k2, 4, 32767, 0, 0, BOUND_EXACT, 0, 7));
      directed.push_back(mk_request(KIND_STORE, k3, 1, 0, 0, -32768, BOUND_LOWER, 'h8001, 0));
      directed.push_back(mk_request(KIND_PROBE, k3, 1, 0, -32768, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_STORE, k4, 0, 0, 0, -28750, BOUND_UNUSED, 'h00FF, 20));
      directed.push_back(mk_request(KIND_PROBE, k4, 0, 32767, -32768, 0, BOUND_EXACT, 0, 20));
      directed.push_back(mk_request(KIND_STORE, k5, 2, 0, 0, 29000, BOUND_LOWER, 'hAAAA, 100));
      directed.push_back(mk_request(KIND_PROBE_ANY, k4, 0, 0, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_PROBE, k5, 2, 0, 0, 0, BOUND_EXACT, 0, 100));
      directed.push_back(mk_request(KIND_UNUSED, k1, 0, 0, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_PROBE, k2, 0, -32768, 0, 0, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_STORE, k2, 3, 0, 0, -29100, BOUND_EXACT, 0, 0));
      directed.push_back(mk_request(KIND_PROBE, k2, 3, 0, 0, 0, BOUND_EXACT, 0, 0));
      foreach (directed[i]) begin
         send_request(directed[i]);
         pace_sender(i == directed.size() - 1);
      end

      run_phase(4'd1, 250, 1'b0);
      wait_for_lookups();
      hold_request = 1'b1;
      run_phase(4'd0, 200, 1'b0);
      sender_idles = 1'b0;
      rsp_idles    = 1'b0;
      run_phase(4'd15, 250, 1'b0);
      sender_idles = 1'b1;
      rsp_idles    = 1'b1;
      run_phase(4'd2, 250, 1'b1);
      run_phase(4'd12, 300, 1'b0);
      wait_for_lookups();
      hold_request = 1'b1;
      run_phase(4'd5, 200, 1'b0);
      run_phase(4'd3, 200, 1'b0);
      run_phase(4'd10, 230, 1'b0);
      wait_for_lookups();

      $display("Run covered %0d requests (%0d stores, %0d lookups checked) over %0d widths",
               requests_sent, model.stores_seen, model.lookups_checked, settings_used + 1);
      $display("Lookups with a hit: %0d, with a usable score: %0d, mismatches: %0d",
               model.hits_seen, model.cutoffs_seen, model.mismatches);
      if (model.mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
